### design/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared constants, types and the RGB555 channel packing for the YUV 4:2:0
// block to RGB555 converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

   localparam int LUMA_W  = 8;
   localparam int PIX_W   = 15;
   localparam int TERM_W  = 17;
   localparam int SUM_W   = 19;
   localparam int MODE_W  = 2;
   localparam int NUM_PIX = 4;

   localparam logic [MODE_W-1:0] MODE_FULL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOUBLE  = 2'd2;

   localparam logic signed [TERM_W-1:0] COEF_V_R = 17'sd358;
   localparam logic signed [TERM_W-1:0] COEF_V_G = 17'sd182;
   localparam logic signed [TERM_W-1:0] COEF_U_G = 17'sd88;
   localparam logic signed [TERM_W-1:0] COEF_U_B = 17'sd453;

   typedef struct packed {
      logic [NUM_PIX-1:0][PIX_W-1:0] pixel;
      logic                          dbl;
   } yrgb_item_type;

   // clamp an 8.8 channel sum to 0..65535 and keep the top five bits
   function automatic logic [4:0] chan5(input logic signed [SUM_W-1:0] s);
      logic [4:0] c;
      if (s[SUM_W-1]) begin
         c = 5'd0;
      end else if (s[SUM_W-2:16] != '0) begin
         c = 5'h1f;
      end else begin
         c = s[15:11];
      end
      return c;
   endfunction

   function automatic logic [PIX_W-1:0] to_rgb555(
      input logic [LUMA_W-1:0]        y,
      input logic signed [TERM_W-1:0] r_term,
      input logic signed [TERM_W-1:0] g_term,
      input logic signed [TERM_W-1:0] b_term
   );
      logic signed [SUM_W-1:0] base;
      logic signed [SUM_W-1:0] r_sum;
      logic signed [SUM_W-1:0] g_sum;
      logic signed [SUM_W-1:0] b_sum;
      base  = $signed({3'b000, y, 8'h00});
      r_sum = base + SUM_W'(r_term);
      g_sum = base - SUM_W'(g_term);
      b_sum = base + SUM_W'(b_term);
      return {chan5(b_sum), chan5(g_sum), chan5(r_sum)};
   endfunction

endpackage

### design/yrgb_expander.sv
// ----------------------------------------------------------------------------
// yrgb_expander
// Holds one converted block and sends it out as two or four result words.
// ----------------------------------------------------------------------------
module yrgb_expander
   import yrgb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  yrgb_item_type in_item,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // pixel_left[14:0], pixel_right[29:15], zero
   output logic          rsp_tuser,   // bottom_row
   output logic          rsp_tlast    // last
);

   logic          valid_ff, valid_in;
   logic [1:0]    cnt_ff, cnt_in;
   yrgb_item_type item_ff, item_in;
   logic [1:0]    sel_left, sel_right;
   logic          last_word;
   logic          word_done;

   always_comb begin
      if (item_ff.dbl) begin
         sel_left  = cnt_ff;
         sel_right = cnt_ff;
         rsp_tuser = cnt_ff[1];
         last_word = (cnt_ff == 2'd3);
      end else begin
         sel_left  = {cnt_ff[0], 1'b0};
         sel_right = {cnt_ff[0], 1'b1};
         rsp_tuser = cnt_ff[0];
         last_word = cnt_ff[0];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_word;
   assign rsp_tdata  = {2'b00, item_ff.pixel[sel_right], item_ff.pixel[sel_left]};
   assign word_done  = valid_ff && rsp_tready;
   assign in_ready   = !valid_ff || (word_done && last_word);

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         cnt_in   = 2'd0;
         item_in  = in_item;
      end else if (word_done) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      item_ff <= item_in;
   end

endmodule

### design/yuv420_block_to_rgb555.sv
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb555
// Converts 2x2 YUV 4:2:0 blocks to RGB555 result words in full, averaged or
// doubled-width mode.
//
//   channel | dir | tdata / data                          | tuser      | tlast
//   req     | in  | tl, tr, bl, br, u, v (8 bits each)    | -          | -
//   rsp     | out | pixel_left[14:0], pixel_right[29:15]  | bottom_row | last
//   csr     | in  | output_mode[1:0], written on csr_we   | -          | -
//
// Three pipeline stages (input, chroma products and luma average, sums and
// packing) feed an output sequencer. It sends two words per block in full and
// averaged modes and four in doubled mode, and takes the next block as the last
// word of a block is accepted. Pipeline stages hold under rsp back-pressure.
// Reset (synchronous) clears valid bits and sets output_mode to full.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb555
   import yrgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,   // luma tl, tr, bl, br, chroma_u, chroma_v
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // pixel_left[14:0], pixel_right[29:15], zero
   output logic              rsp_tuser,   // bottom_row
   output logic              rsp_tlast,   // last
   input  logic              csr_we,
   input  logic [MODE_W-1:0] csr_wdata    // output_mode
);

   logic [MODE_W-1:0] mode_ff;

   // stage 1: input
   logic                             s1_valid_ff;
   logic [NUM_PIX-1:0][LUMA_W-1:0]   s1_luma_ff;
   logic signed [LUMA_W-1:0]         s1_cu_ff, s1_cv_ff;
   logic                             s1_avg_ff, s1_dbl_ff;

   // stage 2: chroma terms
   logic                             s2_valid_ff;
   logic [NUM_PIX-1:0][LUMA_W-1:0]   s2_luma_ff, s2_luma_in;
   logic signed [TERM_W-1:0]         s2_r_ff, s2_g_ff, s2_b_ff;
   logic signed [TERM_W-1:0]         s2_r_in, s2_g_in, s2_b_in;
   logic                             s2_dbl_ff;

   // stage 3: packed pixels
   logic                             s3_valid_ff;
   yrgb_item_type                    s3_item_ff, s3_item_in;

   logic        rdy1, rdy2, rdy3;
   logic [9:0]  luma_sum;
   logic [MODE_W-1:0] req_mode;

   assign rdy2       = !s2_valid_ff || rdy3;
   assign rdy1       = !s1_valid_ff || rdy2;
   assign req_tready = rdy1;
   assign req_mode   = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FULL;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= req_tvalid;
      end
      if (rdy1) begin
         s1_luma_ff <= req_tdata[31:0];
         s1_cu_ff   <= $signed({~req_tdata[39], req_tdata[38:32]});
         s1_cv_ff   <= $signed({~req_tdata[47], req_tdata[46:40]});
         s1_avg_ff  <= (req_mode == MODE_AVERAGE);
         s1_dbl_ff  <= (req_mode == MODE_DOUBLE);
      end
   end

   // stage 2
   always_comb begin
      luma_sum = 10'(s1_luma_ff[0]) + 10'(s1_luma_ff[1])
               + 10'(s1_luma_ff[2]) + 10'(s1_luma_ff[3]);
      s2_luma_in = s1_luma_ff;
      if (s1_avg_ff) begin
         for (int i = 0; i < NUM_PIX; i++) begin
            s2_luma_in[i] = luma_sum[9:2];
         end
      end
      s2_r_in = TERM_W'(s1_cv_ff) * COEF_V_R;
      s2_g_in = TERM_W'(s1_cu_ff) * COEF_U_G + TERM_W'(s1_cv_ff) * COEF_V_G;
      s2_b_in = TERM_W'(s1_cu_ff) * COEF_U_B;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (rdy2) begin
         s2_luma_ff <= s2_luma_in;
         s2_r_ff    <= s2_r_in;
         s2_g_ff    <= s2_g_in;
         s2_b_ff    <= s2_b_in;
         s2_dbl_ff  <= s1_dbl_ff;
      end
   end

   // stage 3
   always_comb begin
      for (int i = 0; i < NUM_PIX; i++) begin
         s3_item_in.pixel[i] = to_rgb555(s2_luma_ff[i], s2_r_ff, s2_g_ff, s2_b_ff);
      end
      s3_item_in.dbl = s2_dbl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (rdy3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (rdy3) begin
         s3_item_ff <= s3_item_in;
      end
   end

   logic exp_ready;

   assign rdy3 = !s3_valid_ff || exp_ready;

   yrgb_expander u_expander (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid_ff),
      .in_ready   (exp_ready),
      .in_item    (s3_item_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/yrgb_checker.sv
// ----------------------------------------------------------------------------
// yrgb_checker
// Port-level checks on the result stream of the block converter.
// ----------------------------------------------------------------------------
module yrgb_checker
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [31:0]       rsp_tdata,
   input logic              rsp_tuser,
   input logic              rsp_tlast
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // final word of a block is always on the lower row
   a_last_bottom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last word not on lower row");

   // a block never stops part way through its words
   a_block_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("block ended without last word");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:30] == 2'b00)
      else $error("rsp_tdata padding not zero");

endmodule

bind yuv420_block_to_rgb555 yrgb_checker u_yrgb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### sim/yuv420_block_to_rgb555_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb555_tb
// Self-checking bench for the 2x2 YUV 4:2:0 block to RGB555 converter. A
// short table of blocks covers the extreme colors and every output mode,
// with known pixels typed in where they are obvious. Random blocks follow
// in several mode phases, with idle cycles on both sides, one calm phase,
// and one long output stall. Every word is checked against the typed-in
// pixels or a local model of the color math.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb555_tb;
   import yrgb_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_BLOCKS = 65;
   localparam int NUM_ROWS     = 20;

   typedef struct packed {
      logic [7:0] tl;
      logic [7:0] tr;
      logic [7:0] bl;
      logic [7:0] br;
      logic [7:0] u;
      logic [7:0] v;
   } yuv_block_type;

   typedef struct packed {
      logic [PIX_W-1:0] left;
      logic [PIX_W-1:0] right;
      logic             bottom;
      logic             last;
   } rgb_word_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              known;
      logic [PIX_W-1:0]  pix;
      yuv_block_type     blk;
   } block_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [47:0]       req_tdata = '0;   // tl, tr, bl, br, u, v
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;        // pixel_left, pixel_right, zero fill
   logic              rsp_tuser;        // bottom_row
   logic              rsp_tlast;        // last
   logic              csr_we = 1'b0;
   logic [MODE_W-1:0] csr_wdata = '0;   // output_mode

   rgb_word_type      pending_words[$];
   logic [MODE_W-1:0] cur_mode = MODE_FULL;
   int                errors = 0;
   int                cycles = 0;
   bit                calm = 1'b0;
   int                hold_requests = 0;
   int                hold_served = 0;
   int                hold_left = 0;

   block_row_type directed[NUM_ROWS] = '{
      '{MODE_FULL,    1'b1, 15'h0000, '{8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128}},
      '{MODE_FULL,    1'b1, 15'h7fff, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128}},
      '{MODE_FULL,    1'b1, 15'h0200, '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0}},
      '{MODE_FULL,    1'b1, 15'h7dff, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}},
      '{MODE_FULL,    1'b1, 15'h70a0, '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0}},
      '{MODE_FULL,    1'b1, 15'h0f5f, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255}},
      '{MODE_FULL,    1'b0, 15'h0000, '{8'd0,   8'd255, 8'd255, 8'd0,   8'd128, 8'd128}},
      '{MODE_FULL,    1'b0, 15'h0000, '{8'd16,  8'd235, 8'd81,  8'd170, 8'd90,  8'd240}},
      '{MODE_FULL,    1'b0, 15'h0000, '{8'd1,   8'd2,   8'd3,   8'd4,   8'd127, 8'd129}},
      '{MODE_AVERAGE, 1'b1, 15'h7fff, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128}},
      '{MODE_AVERAGE, 1'b0, 15'h0000, '{8'd1,   8'd2,   8'd2,   8'd2,   8'd128, 8'd128}},
      '{MODE_AVERAGE, 1'b0, 15'h0000, '{8'd255, 8'd0,   8'd255, 8'd0,   8'd200, 8'd60}},
      '{MODE_AVERAGE, 1'b0, 15'h0000, '{8'd3,   8'd3,   8'd3,   8'd2,   8'd255, 8'd255}},
      '{MODE_DOUBLE,  1'b1, 15'h0000, '{8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128}},
      '{MODE_DOUBLE,  1'b0, 15'h0000, '{8'd0,   8'd85,  8'd170, 8'd255, 8'd64,  8'd192}},
      '{MODE_DOUBLE,  1'b0, 15'h0000, '{8'd255, 8'd128, 8'd64,  8'd1,   8'd0,   8'd255}},
      '{MODE_SPARE,   1'b0, 15'h0000, '{8'd10,  8'd20,  8'd30,  8'd40,  8'd100, 8'd150}},
      '{MODE_SPARE,   1'b1, 15'h7fff, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128}},
      '{MODE_FULL,    1'b0, 15'h0000, '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128}},
      '{MODE_FULL,    1'b0, 15'h0000, '{8'd200, 8'd100, 8'd50,  8'd25,  8'd255, 8'd0}}
   };

   logic [MODE_W-1:0] mode_plan[6] = '{MODE_AVERAGE, MODE_DOUBLE, MODE_SPARE,
                                       MODE_FULL, MODE_DOUBLE, MODE_AVERAGE};

   yuv420_block_to_rgb555 u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // 8.8 channel sum -> clamp to 16 bits -> top five bits
   function automatic logic [4:0] channel_top5(input int sum);
      if (sum < 0) begin
         return 5'd0;
      end else if (sum > 65535) begin
         return 5'd31;
      end
      return 5'(sum >> 11);
   endfunction

   function automatic logic [PIX_W-1:0] yuv_to_rgb555(input logic [7:0] y,
                                                      input int cu, input int cv);
      int base;
      base = int'(y) * 256;
      return {channel_top5(base + 453 * cu),
              channel_top5(base - (88 * cu + 182 * cv)),
              channel_top5(base + 358 * cv)};
   endfunction

   function automatic logic [7:0] pick_sample();
      case ($urandom_range(7))
         0: begin
            return 8'd0;
         end
         1: begin
            return 8'd255;
         end
         default: begin
            return 8'($urandom_range(255));
         end
      endcase
   endfunction

   function automatic yuv_block_type random_block();
      yuv_block_type b;
      b.tl = pick_sample();
      b.tr = pick_sample();
      b.bl = pick_sample();
      b.br = pick_sample();
      b.u  = pick_sample();
      b.v  = pick_sample();
      return b;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycles);
   endtask

   // queue the words one accepted block should produce in the current mode
   task automatic predict_block(input yuv_block_type b, input logic known,
                                input logic [PIX_W-1:0] known_pix);
      int               cu;
      int               cv;
      logic [7:0]       avg;
      logic [PIX_W-1:0] p[4];
      cu  = int'(b.u) - 128;
      cv  = int'(b.v) - 128;
      avg = 8'((int'(b.tl) + int'(b.tr) + int'(b.bl) + int'(b.br)) >> 2);
      if (cur_mode == MODE_AVERAGE) begin
         p[0] = known ? known_pix : yuv_to_rgb555(avg, cu, cv);
         pending_words.push_back('{p[0], p[0], 1'b0, 1'b0});
         pending_words.push_back('{p[0], p[0], 1'b1, 1'b1});
      end else begin
         p[0] = known ? known_pix : yuv_to_rgb555(b.tl, cu, cv);
         p[1] = known ? known_pix : yuv_to_rgb555(b.tr, cu, cv);
         p[2] = known ? known_pix : yuv_to_rgb555(b.bl, cu, cv);
         p[3] = known ? known_pix : yuv_to_rgb555(b.br, cu, cv);
         if (cur_mode == MODE_DOUBLE) begin
            pending_words.push_back('{p[0], p[0], 1'b0, 1'b0});
            pending_words.push_back('{p[1], p[1], 1'b0, 1'b0});
            pending_words.push_back('{p[2], p[2], 1'b1, 1'b0});
            pending_words.push_back('{p[3], p[3], 1'b1, 1'b1});
         end else begin
            pending_words.push_back('{p[0], p[1], 1'b0, 1'b0});
            pending_words.push_back('{p[2], p[3], 1'b1, 1'b1});
         end
      end
   endtask

   task automatic send_block(input yuv_block_type b, input logic known,
                             input logic [PIX_W-1:0] known_pix);
      if (!calm && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b.v, b.u, b.br, b.bl, b.tr, b.tl};
      do @(posedge clock); while (!req_tready);
      predict_block(b, known, known_pix);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_mode = m;
   endtask

   always @(posedge clock) begin : rsp_side
      rgb_word_type got;
      rgb_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[14:0], rsp_tdata[29:15], rsp_tuser, rsp_tlast};
            if (pending_words.size() == 0) begin
               report_mismatch("unexpected word", int'(got), 0);
            end else begin
               want = pending_words.pop_front();
               if (got.left != want.left) begin
                  report_mismatch("pixel_left", got.left, want.left);
               end
               if (got.right != want.right) begin
                  report_mismatch("pixel_right", got.right, want.right);
               end
               if (got.bottom != want.bottom) begin
                  report_mismatch("bottom_row", got.bottom, want.bottom);
               end
               if (got.last != want.last) begin
                  report_mismatch("last", got.last, want.last);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 30);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].mode != cur_mode) begin
            write_mode(directed[i].mode);
         end
         send_block(directed[i].blk, directed[i].known, directed[i].pix);
      end

      foreach (mode_plan[p]) begin
         write_mode(mode_plan[p]);
         calm = (p == 3);
         // long output stall while blocks keep coming
         if (p == 1) begin
            hold_requests++;
         end
         for (int i = 0; i < PHASE_BLOCKS; i++) begin
            send_block(random_block(), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
